// ----- rtl/lsqf_pkg.sv -----
// ----------------------------------------------------------------------------
// lsqf_pkg
// Shared widths, job and write-port types and saturation for the line fit.
// ----------------------------------------------------------------------------
package lsqf_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int X_W   = 16;
  localparam int CNT_W = 7;
  localparam int IDX_W = 6;
  localparam int SX_W  = 23;
  localparam int SXX_W = 38;
  localparam int Q_W   = 48;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SX_W-1:0]  sum_x;
    logic signed [SX_W-1:0]  sum_y;
    logic signed [SXX_W-1:0] sum_xx;
    logic signed [SXX_W-1:0] sum_xy;
    logic                    overflowed;
    logic                    bank;
  } job_t;

  typedef struct packed {
    logic                   en;
    logic                   bank;
    logic [IDX_W-1:0]       idx;
    logic signed [X_W-1:0]  x;
    logic signed [X_W-1:0]  y;
  } wr_t;

  typedef struct packed {
    logic [1:0] fill;
    logic       full;
  } q_stat_t;

  function automatic logic signed [Q_W-1:0] sat48(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd140737488355327;
    lo = -66'sd140737488355328;
    if (v > hi) begin
      sat48 = hi[Q_W-1:0];
    end else if (v < lo) begin
      sat48 = lo[Q_W-1:0];
    end else begin
      sat48 = v[Q_W-1:0];
    end
  endfunction

endpackage

// ----- rtl/lsqf_if.sv -----
// ----------------------------------------------------------------------------
// lsqf_in_if / lsqf_out_if
// Valid/ready channels for points in and fit results out.
// ----------------------------------------------------------------------------
interface lsqf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;
  logic               last_point;
  modport source (output valid, x_value, y_value, last_point, input ready);
  modport sink (input valid, x_value, y_value, last_point, output ready);
endinterface

interface lsqf_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         point_index;
  logic signed [47:0] fitted;
  logic signed [47:0] residual;
  logic signed [47:0] slope;
  logic signed [47:0] intercept;
  logic               degenerate;
  logic               too_many;
  logic               end_of_run;
  modport source (output valid, point_index, fitted, residual, slope, intercept,
                  degenerate, too_many, end_of_run, input ready);
  modport sink (input valid, point_index, fitted, residual, slope, intercept,
                degenerate, too_many, end_of_run, output ready);
endinterface

// ----- rtl/lsqf_front.sv -----
// ----------------------------------------------------------------------------
// lsqf_front
// Accepts points, writes them to the point memory and accumulates the running sums per set.
// ----------------------------------------------------------------------------
module lsqf_front #(
  parameter int MAX_POINTS = lsqf_pkg::DEF_MAX_POINTS
) (
  input  logic            clk,
  input  logic            rst_n,
  lsqf_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            push,
  output lsqf_pkg::job_t  job,
  output lsqf_pkg::wr_t   wr
);
  import lsqf_pkg::*;

  logic [CNT_W-1:0]        count_r;
  logic signed [SX_W-1:0]  sx_r, sy_r;
  logic signed [SXX_W-1:0] sxx_r, sxy_r;
  logic                    ovf_r, bank_r;

  logic                    acc, room;
  logic signed [31:0]      xx, xy;
  logic [CNT_W-1:0]        count_a;
  logic signed [SX_W-1:0]  sx_a, sy_a;
  logic signed [SXX_W-1:0] sxx_a, sxy_a;
  logic                    ovf_a;

  assign in_ch.ready = !q_full;
  assign acc  = in_ch.valid && in_ch.ready;
  assign room = count_r < CNT_W'(MAX_POINTS);
  assign xx   = in_ch.x_value * in_ch.x_value;
  assign xy   = in_ch.x_value * in_ch.y_value;

  always_comb begin
    count_a = count_r;
    sx_a    = sx_r;
    sy_a    = sy_r;
    sxx_a   = sxx_r;
    sxy_a   = sxy_r;
    ovf_a   = ovf_r;
    if (room) begin
      count_a = count_r + 1'b1;
      sx_a    = sx_r + SX_W'(in_ch.x_value);
      sy_a    = sy_r + SX_W'(in_ch.y_value);
      sxx_a   = sxx_r + SXX_W'(xx);
      sxy_a   = sxy_r + SXX_W'(xy);
    end else begin
      ovf_a = 1'b1;
    end
  end

  assign push = acc && in_ch.last_point;
  assign job  = '{count: count_a, sum_x: sx_a, sum_y: sy_a, sum_xx: sxx_a,
                  sum_xy: sxy_a, overflowed: ovf_a, bank: bank_r};
  assign wr   = '{en: acc && room, bank: bank_r, idx: count_r[IDX_W-1:0],
                  x: in_ch.x_value, y: in_ch.y_value};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      sxx_r   <= '0;
      sxy_r   <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
    end else if (acc) begin
      if (in_ch.last_point) begin
        count_r <= '0;
        sx_r    <= '0;
        sy_r    <= '0;
        sxx_r   <= '0;
        sxy_r   <= '0;
        ovf_r   <= 1'b0;
        bank_r  <= !bank_r;
      end else begin
        count_r <= count_a;
        sx_r    <= sx_a;
        sy_r    <= sy_a;
        sxx_r   <= sxx_a;
        sxy_r   <= sxy_a;
        ovf_r   <= ovf_a;
      end
    end
  end

endmodule

// ----- rtl/lsqf_queue.sv -----
// ----------------------------------------------------------------------------
// lsqf_queue
// Two-entry job queue between the front and back parts.
// ----------------------------------------------------------------------------
module lsqf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lsqf_pkg::job_t    job_in,
  input  logic              pop,
  output logic              head_valid,
  output lsqf_pkg::job_t    head,
  output lsqf_pkg::q_stat_t stat
);
  import lsqf_pkg::*;

  job_t       ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;

  assign head_valid = fill_r != 2'd0;
  assign head       = ent_r[rp_r];
  assign stat       = '{fill: fill_r, full: fill_r == 2'd2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= job_in;
    end
  end

endmodule

// ----- rtl/lsqf_back.sv -----
// ----------------------------------------------------------------------------
// lsqf_back
// Point memory and fit sequencer: sums products, divides, emits results.
// ----------------------------------------------------------------------------
module lsqf_back #(
  parameter int MAX_POINTS = lsqf_pkg::DEF_MAX_POINTS
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lsqf_pkg::wr_t  wr,
  input  logic           head_valid,
  input  lsqf_pkg::job_t head,
  output logic           pop,
  lsqf_out_if.source     out_ch
);
  import lsqf_pkg::*;

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_DIVI, S_DIV, S_DIVE, S_RD, S_PROD, S_FIT, S_OUT
  } state_t;

  logic signed [X_W-1:0] mem_x [2][MAX_POINTS];
  logic signed [X_W-1:0] mem_y [2][MAX_POINTS];
  logic signed [X_W-1:0] rd_x_r, rd_y_r;

  state_t              state_r;
  logic [3:0]          step_r;
  logic signed [43:0]  prod_r;
  logic signed [63:0]  acc_r;
  logic signed [Q_W-1:0] den_r;
  logic signed [59:0]  nums_r, numi_r;
  logic                sel_r, neg_r, dovf_r;
  logic [Q_W-1:0]      rem_r, nlo_r, quo_r;
  logic [5:0]          bit_r;
  logic signed [Q_W-1:0] slope_r, icept_r, fit_r, res_r;
  logic signed [63:0]  prod2_r;
  logic [IDX_W-1:0]    idx_r;
  logic                eor_r, degen_r, pop_r;

  logic [2:0]           term;
  logic signed [23:0]   op_a;
  logic signed [SXX_W-1:0] op_b;
  logic signed [43:0]   prod_w;
  logic signed [63:0]   addend, acc_nxt;
  logic signed [59:0]   num_sel;
  logic [59:0]          mag;
  logic [Q_W:0]         trial;
  logic signed [Q_W-1:0] q_sgn;
  logic signed [65:0]   fit_w, res_w;
  logic signed [Q_W-1:0] fit_s;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_x[wr.bank][wr.idx[IW-1:0]] <= wr.x;
      mem_y[wr.bank][wr.idx[IW-1:0]] <= wr.y;
    end
    rd_x_r <= mem_x[head.bank][idx_r[IW-1:0]];
    rd_y_r <= mem_y[head.bank][idx_r[IW-1:0]];
  end

  assign term = step_r[3:1];

  always_comb begin
    unique case (term)
      3'd0: begin
        op_a = 24'(head.count);
        op_b = head.sum_xx;
      end
      3'd1: begin
        op_a = 24'(head.sum_x);
        op_b = SXX_W'(head.sum_x);
      end
      3'd2: begin
        op_a = 24'(head.count);
        op_b = head.sum_xy;
      end
      3'd3: begin
        op_a = 24'(head.sum_x);
        op_b = SXX_W'(head.sum_y);
      end
      3'd4: begin
        op_a = 24'(head.sum_y);
        op_b = head.sum_xx;
      end
      default: begin
        op_a = 24'(head.sum_x);
        op_b = head.sum_xy;
      end
    endcase
    if (step_r[0]) begin
      prod_w = 44'(op_a * $signed(op_b[37:19]));
    end else begin
      prod_w = 44'(op_a * $signed({1'b0, op_b[18:0]}));
    end
    addend  = step_r[0] ? (64'(prod_r) <<< 19) : 64'(prod_r);
    acc_nxt = term[0] ? acc_r - addend : acc_r + addend;
  end

  assign num_sel = sel_r ? numi_r : nums_r;
  assign mag     = num_sel[59] ? 60'(-num_sel) : 60'(num_sel);
  assign trial   = {rem_r, nlo_r[Q_W-1]};

  always_comb begin
    if (dovf_r || quo_r[Q_W-1]) begin
      q_sgn = neg_r ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      q_sgn = neg_r ? -$signed(quo_r) : $signed(quo_r);
    end
    fit_w = 66'(prod2_r) + 66'(icept_r);
    fit_s = sat48(fit_w);
    res_w = 66'(fit_s) - (66'(rd_y_r) <<< 16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pop_r   <= 1'b0;
    end else begin
      pop_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (head_valid && !pop_r) begin
            acc_r   <= '0;
            step_r  <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= prod_w;
          state_r <= S_ACC;
        end
        S_ACC: begin
          if (step_r[1:0] == 2'd3) begin
            acc_r <= '0;
            unique case (step_r[3:2])
              2'd0:    den_r  <= acc_nxt[Q_W-1:0];
              2'd1:    nums_r <= acc_nxt[59:0];
              default: numi_r <= acc_nxt[59:0];
            endcase
          end else begin
            acc_r <= acc_nxt;
          end
          step_r <= step_r + 1'b1;
          if (step_r == 4'd11) begin
            sel_r   <= 1'b0;
            state_r <= S_DIVI;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_DIVI: begin
          degen_r <= den_r <= 0;
          if (den_r <= 0) begin
            slope_r <= '0;
            icept_r <= '0;
            idx_r   <= '0;
            state_r <= S_RD;
          end else begin
            neg_r   <= num_sel[59];
            dovf_r  <= Q_W'(mag[59:32]) >= den_r;
            rem_r   <= Q_W'(mag[59:32]);
            nlo_r   <= {mag[31:0], 16'd0};
            quo_r   <= '0;
            bit_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (trial >= (Q_W+1)'(den_r)) begin
            rem_r <= Q_W'(trial - (Q_W+1)'(den_r));
            quo_r <= {quo_r[Q_W-2:0], 1'b1};
          end else begin
            rem_r <= trial[Q_W-1:0];
            quo_r <= {quo_r[Q_W-2:0], 1'b0};
          end
          nlo_r <= {nlo_r[Q_W-2:0], 1'b0};
          bit_r <= bit_r + 1'b1;
          if (bit_r == 6'(Q_W-1)) begin
            state_r <= S_DIVE;
          end
        end
        S_DIVE: begin
          if (!sel_r) begin
            slope_r <= q_sgn;
            sel_r   <= 1'b1;
            state_r <= S_DIVI;
          end else begin
            icept_r <= q_sgn;
            idx_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= S_PROD;
        end
        S_PROD: begin
          prod2_r <= 64'(slope_r * rd_x_r);
          state_r <= S_FIT;
        end
        S_FIT: begin
          fit_r   <= degen_r ? '0 : fit_s;
          res_r   <= degen_r ? '0 : sat48(res_w);
          eor_r   <= CNT_W'(idx_r) + 1'b1 == head.count;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            if (eor_r) begin
              pop_r   <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign pop                = state_r == S_OUT && out_ch.ready && eor_r;
  assign out_ch.valid       = state_r == S_OUT;
  assign out_ch.point_index = idx_r;
  assign out_ch.fitted      = fit_r;
  assign out_ch.residual    = res_r;
  assign out_ch.slope       = slope_r;
  assign out_ch.intercept   = icept_r;
  assign out_ch.degenerate  = degen_r;
  assign out_ch.too_many    = head.overflowed;
  assign out_ch.end_of_run  = eor_r;

endmodule

// ----- rtl/least_squares_line_fit_unit.sv -----
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit
// Least-squares line fit over sets of integer points with per-point results.
// ----------------------------------------------------------------------------
// Points are accepted one per cycle unless input stalls, and are stored in one
// of two memory banks while running sums are kept; the point flagged last
// closes the set and queues it. A new set streams in while the previous one is
// fitted; input stalls only while two closed sets wait. Besides output stalls,
// each set costs shared-multiplier work on six terms, two bit-serial 48-step
// divides (none if degenerate), and read, product, fit and output per result.
module least_squares_line_fit_unit #(
  parameter int MAX_POINTS = lsqf_pkg::DEF_MAX_POINTS
) (
  input logic        clk,
  input logic        rst_n,
  lsqf_in_if.sink    in_ch,
  lsqf_out_if.source out_ch
);
  import lsqf_pkg::*;

  logic    push, pop, head_valid;
  job_t    job, head;
  wr_t     wr;
  q_stat_t q_stat;

  lsqf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_full(q_stat.full),
    .push(push), .job(job), .wr(wr)
  );

  lsqf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .job_in(job), .pop(pop),
    .head_valid(head_valid), .head(head), .stat(q_stat)
  );

  lsqf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst_n(rst_n), .wr(wr), .head_valid(head_valid), .head(head),
    .pop(pop), .out_ch(out_ch)
  );

  a_out_has_job: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> q_stat.fill != 2'd0)
    else $error("result without a queued set");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_stat.fill == 2'd2)
    else $error("input stalled with queue room");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.degenerate) |-> (out_ch.slope == 48'sd0 &&
      out_ch.fitted == 48'sd0 && out_ch.residual == 48'sd0))
    else $error("degenerate result not zero");

endmodule

// ----- tb/sv/least_squares_line_fit_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// least_squares_line_fit_unit_tb
// Drives point sets into the line fit and checks every per-point result
// against a fit worked out in the bench from the same accepted points.
// Covers degenerate sets, extreme coordinates, capacity overflow, and
// random sets under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module least_squares_line_fit_unit_tb;
  import lsqf_pkg::*;

  localparam int  CAPACITY = DEF_MAX_POINTS;
  localparam int  WATCHDOG_LIMIT = 40000;
  localparam longint MAX48 = 64'sd140737488355327;
  localparam longint MIN48 = -64'sd140737488355328;

  typedef struct {
    logic [5:0]         point_index;
    logic signed [47:0] fitted;
    logic signed [47:0] residual;
    logic signed [47:0] slope;
    logic signed [47:0] intercept;
    logic               degenerate;
    logic               too_many;
    logic               end_of_run;
  } fit_result_t;

  logic clk;
  logic rst_n;

  lsqf_in_if  in_ch ();
  lsqf_out_if out_ch ();

  least_squares_line_fit_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fit_result_t pending_fits[$];
  int          fail_count;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;

  int     set_count;
  longint acc_x, acc_y, acc_xx, acc_xy;
  bit     set_overflowed;
  longint set_x[CAPACITY];
  longint set_y[CAPACITY];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint clamp48(longint v);
    if (v > MAX48) return MAX48;
    if (v < MIN48) return MIN48;
    return v;
  endfunction

  function automatic longint q16_quotient(longint num, longint den);
    longint q, r;
    q = num / den;
    r = num % den;
    if (q > (64'sd1 <<< 32)) return MAX48;
    if (q < -(64'sd1 <<< 32)) return MIN48;
    return clamp48(q * 65536 + (r * 65536) / den);
  endfunction

  function automatic void clear_set();
    set_count = 0;
    acc_x = 0;
    acc_y = 0;
    acc_xx = 0;
    acc_xy = 0;
    set_overflowed = 0;
  endfunction

  function automatic void accept_point(logic signed [15:0] xv, logic signed [15:0] yv,
                                       logic last);
    longint x, y, n, den, slope_q, icept_q, fit_q, res_q;
    bit degen;
    fit_result_t r;
    x = xv;
    y = yv;
    if (set_count < CAPACITY) begin
      set_x[set_count] = x;
      set_y[set_count] = y;
      set_count++;
      acc_x += x;
      acc_y += y;
      acc_xx += x * x;
      acc_xy += x * y;
    end else begin
      set_overflowed = 1;
    end
    if (!last) return;
    n = set_count;
    den = n * acc_xx - acc_x * acc_x;
    degen = (den <= 0);
    slope_q = 0;
    icept_q = 0;
    if (!degen) begin
      slope_q = q16_quotient(n * acc_xy - acc_x * acc_y, den);
      icept_q = q16_quotient(acc_y * acc_xx - acc_x * acc_xy, den);
    end
    for (int i = 0; i < set_count; i++) begin
      fit_q = 0;
      res_q = 0;
      if (!degen) begin
        fit_q = clamp48(slope_q * set_x[i] + icept_q);
        res_q = clamp48(fit_q - set_y[i] * 65536);
      end
      r.point_index = i[5:0];
      r.fitted      = fit_q[47:0];
      r.residual    = res_q[47:0];
      r.slope       = slope_q[47:0];
      r.intercept   = icept_q[47:0];
      r.degenerate  = degen;
      r.too_many    = set_overflowed;
      r.end_of_run  = (i + 1 == set_count);
      pending_fits.push_back(r);
    end
    clear_set();
  endfunction

  // Receiver: random stalls on ready.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest pending one.
  always @(posedge clk) begin
    fit_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_fits.size() == 0) begin
        $display("%0t unexpected result: index %0d fitted %h", $time,
                 out_ch.point_index, out_ch.fitted);
        fail_count++;
      end else begin
        e = pending_fits.pop_front();
        if (out_ch.point_index !== e.point_index) begin
          $display("%0t point_index expected %0d actual %0d", $time, e.point_index,
                   out_ch.point_index);
          fail_count++;
        end
        if (out_ch.fitted !== e.fitted) begin
          $display("%0t fitted expected %h actual %h", $time, e.fitted, out_ch.fitted);
          fail_count++;
        end
        if (out_ch.residual !== e.residual) begin
          $display("%0t residual expected %h actual %h", $time, e.residual,
                   out_ch.residual);
          fail_count++;
        end
        if (out_ch.slope !== e.slope) begin
          $display("%0t slope expected %h actual %h", $time, e.slope, out_ch.slope);
          fail_count++;
        end
        if (out_ch.intercept !== e.intercept) begin
          $display("%0t intercept expected %h actual %h", $time, e.intercept,
                   out_ch.intercept);
          fail_count++;
        end
        if (out_ch.degenerate !== e.degenerate) begin
          $display("%0t degenerate expected %b actual %b", $time, e.degenerate,
                   out_ch.degenerate);
          fail_count++;
        end
        if (out_ch.too_many !== e.too_many) begin
          $display("%0t too_many expected %b actual %b", $time, e.too_many,
                   out_ch.too_many);
          fail_count++;
        end
        if (out_ch.end_of_run !== e.end_of_run) begin
          $display("%0t end_of_run expected %b actual %b", $time, e.end_of_run,
                   out_ch.end_of_run);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles with no item moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog timeout, %0d results pending", $time, pending_fits.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_point(input logic signed [15:0] xv, input logic signed [15:0] yv,
                            input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.x_value    <= xv;
    in_ch.y_value    <= yv;
    in_ch.last_point <= last;
    do @(posedge clk); while (!in_ch.ready);
    accept_point(xv, yv, last);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_fits.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return $signed(16'($urandom_range(64))) - 16'sd32;
      2: return ($urandom_range(1) != 0) ? 16'sh7fff - 16'($urandom_range(3))
                                         : 16'sh8000 + 16'($urandom_range(3));
      default: return $signed(16'($urandom_range(2000))) - 16'sd1000;
    endcase
  endfunction

  task automatic send_random_set(input int n_points);
    int slope_i, icept_i, xi, yi;
    bit linear, same_x;
    logic signed [15:0] fixed_x;
    linear  = ($urandom_range(2) == 0);
    same_x  = ($urandom_range(15) == 0);
    fixed_x = rand_coord();
    slope_i = $signed(32'($urandom_range(20))) - 10;
    icept_i = $signed(32'($urandom_range(2000))) - 1000;
    for (int i = 0; i < n_points; i++) begin
      xi = same_x ? fixed_x : rand_coord();
      if (linear) begin
        xi = $signed(32'($urandom_range(2000))) - 1000;
        yi = slope_i * xi + icept_i + $signed(32'($urandom_range(6))) - 3;
      end else begin
        yi = rand_coord();
      end
      send_point(xi[15:0], yi[15:0], i == n_points - 1);
    end
  endtask

  task automatic test_degenerate_sets();
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(16'sd5, 16'sd1, 1'b0);
    send_point(16'sd5, 16'sd3, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh8000, 1'b1);
  endtask

  task automatic test_extreme_points();
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b1);
    send_point(16'sd0, 16'sh8000, 1'b0);
    send_point(16'sd1, 16'sh7fff, 1'b1);
    send_point(-16'sd1, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sh7fff, 1'b1);
  endtask

  task automatic test_capacity();
    for (int i = 0; i < CAPACITY; i++) begin
      send_point(rand_coord(), rand_coord(), i == CAPACITY - 1);
    end
    for (int i = 0; i < CAPACITY + 2; i++) begin
      send_point(rand_coord(), rand_coord(), i == CAPACITY + 1);
    end
    for (int i = 0; i < CAPACITY + 1; i++) begin
      send_point(16'(i * 311), rand_coord(), i == CAPACITY);
    end
  endtask

  task automatic test_drain_pause();
    send_random_set(5);
    wait_drained();
    send_random_set(3);
  endtask

  task automatic test_random_sets(input int n_items);
    int sent, n;
    sent = 0;
    while (sent < n_items) begin
      n = ($urandom_range(19) == 0) ? $urandom_range(CAPACITY - 16, CAPACITY)
                                    : $urandom_range(1, 8);
      send_random_set(n);
      sent += n;
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.x_value    <= '0;
    in_ch.y_value    <= '0;
    in_ch.last_point <= 1'b0;
    fail_count    = 0;
    idle_cycles   = 0;
    send_idle_pct = 35;
    recv_idle_pct = 65;
    clear_set();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_degenerate_sets();
    test_extreme_points();
    test_capacity();
    test_drain_pause();
    test_random_sets(80);
    send_idle_pct = 65;
    recv_idle_pct = 35;
    test_random_sets(80);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sets(80);

    wait_drained();
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/lsqf_pkg.sv
rtl/lsqf_if.sv
rtl/lsqf_front.sv
rtl/lsqf_queue.sv
rtl/lsqf_back.sv
rtl/least_squares_line_fit_unit.sv
tb/sv/least_squares_line_fit_unit_tb.sv
